// File: rtl/ppsort_pkg.sv
// ----------------------------------------------------------------------------
// ppsort_pkg
// Shared constants and types of the prime partition sorter.
// ----------------------------------------------------------------------------
package ppsort_pkg;

   localparam int PPS_MAX_ITEMS = 64;
   localparam int VALUE_W       = 32;
   localparam int DIV_W         = 16;
   localparam int BIT_CNT_W     = 5;

   typedef struct packed {
      logic done;
      logic prime;
   } prime_status_type;

endpackage

// File: rtl/ppsort_ram.sv
// ----------------------------------------------------------------------------
// ppsort_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppsort_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ppsort_prime_unit.sv
// ----------------------------------------------------------------------------
// ppsort_prime_unit
// Trial division primality test built around one serial remainder unit.
// ----------------------------------------------------------------------------
module ppsort_prime_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [31:0]          value,
   output ppsort_pkg::prime_status_type status
);
   import ppsort_pkg::*;

   localparam logic [1:0] PU_IDLE  = 2'd0;
   localparam logic [1:0] PU_CHECK = 2'd1;
   localparam logic [1:0] PU_DIV   = 2'd2;
   localparam logic [1:0] PU_NEXT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [VALUE_W-1:0]   n_ff, n_in;
   logic [VALUE_W-1:0]   shift_ff, shift_in;
   logic [VALUE_W-1:0]   sq_ff, sq_in;
   logic [DIV_W-1:0]     d_ff, d_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic                 done_ff, done_in;
   logic                 prime_ff, prime_in;
   logic [DIV_W:0]       trial;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      shift_in = shift_ff;
      sq_in    = sq_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      prime_in = prime_ff;
      trial    = {rem_ff, shift_ff[VALUE_W-1]};
      case (state_ff)
         PU_IDLE: begin
            if (start) begin
               n_in  = value;
               d_in  = DIV_W'(2);
               sq_in = VALUE_W'(4);
               if (value < 32'sd2) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  state_in = PU_CHECK;
               end
            end
         end
         PU_CHECK: begin
            if (sq_ff > n_ff) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
               state_in = PU_IDLE;
            end else begin
               rem_in   = '0;
               shift_in = n_ff;
               bit_in   = '1;
               state_in = PU_DIV;
            end
         end
         PU_DIV: begin
            if (trial >= {1'b0, d_ff}) begin
               rem_in = DIV_W'(trial - {1'b0, d_ff});
            end else begin
               rem_in = trial[DIV_W-1:0];
            end
            shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
            bit_in   = bit_ff - BIT_CNT_W'(1);
            if (bit_ff == '0) begin
               state_in = PU_NEXT;
            end
         end
         PU_NEXT: begin
            if (rem_ff == '0) begin
               done_in  = 1'b1;
               prime_in = 1'b0;
               state_in = PU_IDLE;
            end else begin
               sq_in    = sq_ff + VALUE_W'({d_ff, 1'b1});
               d_in     = d_ff + DIV_W'(1);
               state_in = PU_CHECK;
            end
         end
         default: begin
            state_in = PU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff     <= n_in;
      shift_ff <= shift_in;
      sq_ff    <= sq_in;
      d_ff     <= d_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      prime_ff <= prime_in;
   end

   assign status.done  = done_ff;
   assign status.prime = prime_ff;

endmodule

// File: rtl/prime_partition_sorter.sv
// ----------------------------------------------------------------------------
// prime_partition_sorter
// Collects a set of signed values, then emits primes descending followed by
// non-primes ascending.
// ----------------------------------------------------------------------------
// Values load at one beat per cycle until a beat with last_in set; beats past
// MAX_ITEMS are dropped and flag overflow on every result of that set. After
// the last beat the input stalls while each stored value is tested by one
// serial remainder unit, one trial divisor at a time, with up to sqrt(value)
// divisors. The ordered burst then comes out by selection over the single RAM
// read port: each result beat follows a full scan of the stored set, and the
// result side may stall it. Input resumes after the final result beat is taken.
module prime_partition_sorter #(
   parameter int MAX_ITEMS = ppsort_pkg::PPS_MAX_ITEMS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sorted_value,
   output logic               rsp_is_prime_out,
   output logic               rsp_last_out,
   output logic               rsp_overflow
);
   import ppsort_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int ENT_W = VALUE_W + 1;

   localparam logic [2:0] ST_LOAD     = 3'd0;
   localparam logic [2:0] ST_TEST_RD  = 3'd1;
   localparam logic [2:0] ST_TEST_GO  = 3'd2;
   localparam logic [2:0] ST_TEST_RUN = 3'd3;
   localparam logic [2:0] ST_SCAN     = 3'd4;
   localparam logic [2:0] ST_SCAN_END = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;
   localparam logic [2:0] ST_WAIT     = 3'd7;

   function automatic logic [ENT_W-1:0] order_key(input logic [ENT_W-1:0] ent);
      logic [VALUE_W-1:0] biased;
      biased = ent[VALUE_W-1:0] ^ {1'b1, {(VALUE_W-1){1'b0}}};
      return {~ent[VALUE_W], biased ^ {VALUE_W{ent[VALUE_W]}}};
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 dropped_ff, dropped_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [MAX_ITEMS-1:0] used_ff, used_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 have_best_ff, have_best_in;
   logic [ENT_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_prime_ff, rsp_prime_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENT_W-1:0]     ram_wr_data;
   logic [ENT_W-1:0]     ram_rd_data;
   logic                 pu_start;
   prime_status_type     pu_status;
   logic                 idx_is_last;

   assign idx_is_last = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      used_in      = used_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      have_best_in = have_best_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = {pu_status.prime, val_ff};
      pu_start     = 1'b0;

      if (rd_valid_ff && !used_ff[rd_idx_ff] &&
          (!have_best_ff || (order_key(ram_rd_data) < order_key(best_ff)))) begin
         have_best_in = 1'b1;
         best_in      = ram_rd_data;
         best_idx_in  = rd_idx_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[IDX_W-1:0];
                  ram_wr_data = {1'b0, req_value};
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_in) begin
                  idx_in   = '0;
                  state_in = ST_TEST_RD;
               end
            end
         end
         ST_TEST_RD: begin
            state_in = ST_TEST_GO;
         end
         ST_TEST_GO: begin
            pu_start = 1'b1;
            val_in   = ram_rd_data[VALUE_W-1:0];
            state_in = ST_TEST_RUN;
         end
         ST_TEST_RUN: begin
            if (pu_status.done) begin
               ram_wr_en = 1'b1;
               if (idx_is_last) begin
                  idx_in       = '0;
                  remain_in    = count_ff;
                  used_in      = '0;
                  have_best_in = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_TEST_RD;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_idx_in   = idx_ff;
            if (idx_is_last) begin
               state_in = ST_SCAN_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in         = 1'b1;
            rsp_value_in         = best_ff[VALUE_W-1:0];
            rsp_prime_in         = best_ff[VALUE_W];
            rsp_last_in          = (remain_ff == CNT_W'(1));
            rsp_ovf_in           = dropped_ff;
            used_in[best_idx_ff] = 1'b1;
            remain_in            = remain_ff - CNT_W'(1);
            state_in             = ST_WAIT;
         end
         ST_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (remain_ff == '0) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  idx_in       = '0;
                  have_best_in = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remain_ff    <= remain_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      used_ff      <= used_in;
      rd_idx_ff    <= rd_idx_in;
      have_best_ff <= have_best_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   ppsort_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   ppsort_prime_unit u_prime (
      .clock  (clock),
      .reset  (reset),
      .start  (pu_start),
      .value  (val_in),
      .status (pu_status)
   );

   assign req_stall        = (state_ff != ST_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_is_prime_out = rsp_prime_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

// File: rtl/ppsort_checker.sv
// ----------------------------------------------------------------------------
// ppsort_checker
// Port-level checks of the prime partition sorter, bound to the top level.
// ----------------------------------------------------------------------------
module ppsort_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_sorted_value,
   input logic               rsp_is_prime_out,
   input logic               rsp_last_out,
   input logic               rsp_overflow
);

   logic prev_np_ff;
   logic rsp_beat;

   assign rsp_beat = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_np_ff <= 1'b0;
      end else if (rsp_beat) begin
         prev_np_ff <= !rsp_is_prime_out && !rsp_last_out;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_load_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result is pending");

   a_prime_above_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime_out |-> rsp_sorted_value > 32'sd1)
      else $error("value below two marked prime");

   a_partition_order: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && prev_np_ff |-> !rsp_is_prime_out)
      else $error("prime beat after a non-prime beat in one burst");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_value) &&
         $stable(rsp_is_prime_out) && $stable(rsp_last_out) && $stable(rsp_overflow))
      else $error("stalled result changed");

endmodule

bind prime_partition_sorter ppsort_checker u_ppsort_checker (.*);

// File: tb/sv/prime_partition_sorter_tb.sv
// ----------------------------------------------------------------------------
// prime_partition_sorter_tb
// Self-checking testbench of the prime partition sorter.
// ----------------------------------------------------------------------------
// A table of directed sets comes first: single-value sets whose one result is
// typed in, then a mixed set with small primes, squares, a negative and equal
// values. Random sets follow, among them one past capacity and one exactly
// full. An internal model of the sorter predicts each burst. Both channels
// idle in random bursts, and the result side once holds off for a long
// stretch while new beats are offered.
// ----------------------------------------------------------------------------
module prime_partition_sorter_tb;

   import ppsort_pkg::*;

   localparam int CAP = PPS_MAX_ITEMS;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      prime;
      logic                      last;
      logic                      dropped;
   } sorted_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      typed;
      logic                      prime;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last_in = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_sorted_value;
   logic                      rsp_is_prime_out;
   logic                      rsp_last_out;
   logic                      rsp_overflow;

   logic row_typed = 1'b0;
   logic row_prime = 1'b0;

   logic signed [VALUE_W-1:0] set_values[$];
   bit                        set_marks[$];
   bit                        set_dropped = 1'b0;
   sorted_beat_type           pending_sorted[$];
   plan_row_type              plan[$];

   int failures = 0;
   int beats_sent = 0;
   int results_checked = 0;
   int bursts_seen = 0;
   int dropped_bursts = 0;
   int long_holds = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   bit hold_armed = 1'b0;

   prime_partition_sorter #(.MAX_ITEMS(CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_is_prime_out (rsp_is_prime_out),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #120000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic bit trial_prime(input logic signed [VALUE_W-1:0] v);
      longint n;
      longint d;
      if (v < 2) return 1'b0;
      n = v;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Stores one accepted beat and, on the closing beat, queues the burst.
   function automatic void take_value(input logic signed [VALUE_W-1:0] v, input bit last,
                                      input bit typed, input bit typed_prime);
      logic signed [VALUE_W-1:0] primes_desc[0:CAP-1];
      logic signed [VALUE_W-1:0] others_asc[0:CAP-1];
      logic signed [VALUE_W-1:0] x;
      sorted_beat_type b;
      int pc;
      int nc;
      int i;
      int j;
      pc = 0;
      nc = 0;
      if (set_values.size() < CAP) begin
         set_values.push_back(v);
         set_marks.push_back(trial_prime(v));
      end else begin
         set_dropped = 1'b1;
      end
      if (!last) return;
      for (i = 0; i < set_values.size(); i++) begin
         x = set_values[i];
         if (set_marks[i]) begin
            j = pc;
            while (j > 0 && primes_desc[j-1] < x) begin
               primes_desc[j] = primes_desc[j-1];
               j--;
            end
            primes_desc[j] = x;
            pc++;
         end else begin
            j = nc;
            while (j > 0 && others_asc[j-1] > x) begin
               others_asc[j] = others_asc[j-1];
               j--;
            end
            others_asc[j] = x;
            nc++;
         end
      end
      if (typed) begin
         b.value = v;
         b.prime = typed_prime;
         b.last = 1'b1;
         b.dropped = 1'b0;
         pending_sorted.push_back(b);
      end else begin
         for (i = 0; i < pc + nc; i++) begin
            b.value = (i < pc) ? primes_desc[i] : others_asc[i-pc];
            b.prime = (i < pc);
            b.last = (i == pc + nc - 1);
            b.dropped = set_dropped;
            pending_sorted.push_back(b);
         end
      end
      set_values.delete();
      set_marks.delete();
      set_dropped = 1'b0;
   endfunction

   function automatic void check_field(input string what, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : track
      sorted_beat_type want;
      if (!reset && req_valid && !req_stall) begin
         take_value(req_value, req_last_in, row_typed, row_prime);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sorted.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual %0d",
                     $time, rsp_sorted_value);
            failures++;
         end else begin
            want = pending_sorted.pop_front();
            check_field("sorted_value", want.value, rsp_sorted_value);
            check_field("is_prime_out", want.prime, rsp_is_prime_out);
            check_field("last_out", want.last, rsp_last_out);
            check_field("overflow", want.dropped, rsp_overflow);
            results_checked++;
         end
         if (rsp_last_out === 1'b1) begin
            bursts_seen++;
            if (rsp_overflow === 1'b1) dropped_bursts++;
         end
      end
   end

   initial begin : rsp_pacing
      int n;
      forever begin
         @(negedge clock);
         if (hold_armed && rsp_valid) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < 300; n++) @(negedge clock);
            rsp_stall <= 1'b0;
            long_holds++;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(input logic signed [VALUE_W-1:0] v, input bit last,
                            input bit typed, input bit prime);
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last_in <= last;
      row_typed <= typed;
      row_prime <= prime;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      longint p;
      case ($urandom_range(0, 19))
         0, 1, 2: return {1'b1, 31'($urandom)};
         3, 4:    return {1'b0, 30'($urandom), 1'b0};
         5, 6: begin
            p = 3 * longint'($urandom_range(1, 715827882));
            return p[VALUE_W-1:0];
         end
         7:       return $urandom_range(2, 100000);
         8, 9:    return -$signed(32'($urandom_range(1, 50)));
         default: return $urandom_range(0, 300);
      endcase
   endfunction

   task automatic send_set(input int len);
      int i;
      for (i = 0; i < len; i++) send_beat(pick_value(), i == len - 1, 1'b0, 1'b0);
   endtask

   function automatic void add_row(input logic signed [VALUE_W-1:0] v, input bit last,
                                   input bit typed, input bit prime);
      plan_row_type r;
      r.value = v;
      r.last = last;
      r.typed = typed;
      r.prime = prime;
      plan.push_back(r);
   endfunction

   initial begin : stimulus
      int i;
      bit full_done;
      full_done = 1'b0;
      //      value         last typed prime
      add_row(7,            1,   1,    1);
      add_row(-2147483648,  1,   1,    0);
      add_row(2147483647,   1,   1,    1);
      add_row(2,            1,   1,    1);
      add_row(1,            1,   1,    0);
      add_row(0,            0,   0,    0);
      add_row(-1,           0,   0,    0);
      add_row(4,            0,   0,    0);
      add_row(3,            0,   0,    0);
      add_row(25,           0,   0,    0);
      add_row(49,           0,   0,    0);
      add_row(5,            0,   0,    0);
      add_row(5,            0,   0,    0);
      add_row(6,            0,   0,    0);
      add_row(6,            0,   0,    0);
      add_row(97,           0,   0,    0);
      add_row(2147483646,   0,   0,    0);
      add_row(121,          1,   0,    0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < plan.size(); i++) begin
         send_beat(plan[i].value, plan[i].last, plan[i].typed, plan[i].prime);
      end

      // The next burst is held back while the following set is offered.
      hold_armed = 1'b1;
      send_set(CAP + 2);
      while (beats_sent < 165) begin
         if (!full_done && beats_sent > 100) begin
            send_set(CAP);
            full_done = 1'b1;
         end else begin
            send_set($urandom_range(1, 8));
         end
      end
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      while (beats_sent < 205) send_set($urandom_range(1, 8));

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d value beats; checked %0d sorted results in %0d bursts.",
               beats_sent, results_checked, bursts_seen);
      $display("%0d bursts carried dropped values; %0d long result hold-offs applied.",
               dropped_bursts, long_holds);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
